// ===== src/rhcb_pkg.sv =====
`default_nettype none
package rhcb_pkg;

  // field and register widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEFT_W  = 32;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned BS_W    = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned SKIP_W  = 8;
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned CFG_DW  = 16;

  // rolling window
  localparam int unsigned WINDOW     = 7;
  localparam int unsigned WIN_AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned ROLL_SHIFT = 5;

  // remainder unit: radix-16, one nibble of the dividend per cycle
  localparam int unsigned RADIX_BITS = 4;
  localparam int unsigned REM_STEPS  = HASH_W / RADIX_BITS;
  localparam int unsigned REM_CW     = $clog2(REM_STEPS);

  // stream packing
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 56;
  localparam int unsigned M_TUSER_W = 2;

  // reset values of the configuration registers
  localparam logic [BS_W-1:0]   BLOCK_SIZE_RST = 16'd320;
  localparam logic [LEN_W-1:0]  MAX_CHUNK_RST  = 16'd16384;
  localparam logic [SKIP_W-1:0] SKIP_COUNT_RST = 8'd80;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_CHUNK  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SKIP_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROLL,
    ST_HSUM,
    ST_DIV,
    ST_FIN
  } rhcb_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch input beat
    logic roll;    // update window, sums, chunk length
    logic start;   // form hash, start remainder
    logic commit;  // decide close/skip, write output register
  } rhcb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;      // current byte is skipped
    logic rem_done;  // remainder ready next cycle
    logic out_free;  // output register can take a beat
  } rhcb_sts_t;

endpackage
`default_nettype wire

// ===== src/rhcb_rem.sv =====
`default_nettype none
module rhcb_rem
  import rhcb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [HASH_W-1:0] dividend_i,
  input  wire logic [BS_W-1:0]   divisor_i,
  output logic                   done_o,
  output logic [BS_W-1:0]        rem_o
);

  logic              busy_q, busy_d;
  logic [REM_CW-1:0] cnt_q, cnt_d;
  logic [HASH_W-1:0] dvd_q, dvd_d;
  logic [BS_W-1:0]   rem_q, rem_d;
  logic [BS_W-1:0]   rem_step;

  // four restoring steps per cycle on the top nibble
  always_comb begin
    logic [BS_W:0]   t;
    logic [BS_W-1:0] r;
    r = rem_q;
    t = '0;
    for (int i = 0; i < RADIX_BITS; i++) begin
      t = {r, dvd_q[HASH_W-1-i]};
      if (t >= {1'b0, divisor_i}) begin
        t = t - {1'b0, divisor_i};
      end
      r = t[BS_W-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << RADIX_BITS;
      rem_d = rem_step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == REM_CW'(REM_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  // last step in flight: remainder is final after this edge
  assign done_o = busy_q && (cnt_q == REM_CW'(REM_STEPS - 1));
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== src/rhcb_datapath.sv =====
`default_nettype none
module rhcb_datapath
  import rhcb_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_AW-1:0]    cfg_addr_i,
  input  wire logic [CFG_DW-1:0]    cfg_wdata_i,
  input  wire logic [S_TDATA_W-1:0] in_data_i,
  input  wire rhcb_cmd_t            cmd_i,
  output rhcb_sts_t                 sts_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [M_TDATA_W-1:0]      out_data_o,
  output logic [M_TUSER_W-1:0]      out_user_o,
  output logic                      out_last_o
);

  // configuration
  logic [BS_W-1:0]   bs_q;
  logic [LEN_W-1:0]  mc_q;
  logic [SKIP_W-1:0] sc_q;

  // input beat
  logic [BYTE_W-1:0] byte_q;
  logic [LEFT_W-1:0] left_q;

  // hash state
  logic [BYTE_W-1:0] win_q [WINDOW];
  logic [WIN_AW-1:0] wpos_q;
  logic [HASH_W-1:0] wsum_q, wtd_q, sx_q, hash_q;
  logic [LEN_W-1:0]  len_q;
  logic [SKIP_W-1:0] skip_q;
  logic              inch_q;

  // output register
  logic              m_valid_q;
  logic [BYTE_W-1:0] o_byte_q;
  logic              o_inch_q, o_cend_q, o_last_q;
  logic [HASH_W-1:0] o_roll_q;
  logic [LEN_W-1:0]  o_pos_q;

  logic [HASH_W-1:0] c_ext, old_ext, wtd_new, wsum_new, sx_new, hash_sum;
  logic [WIN_AW-1:0] wpos_new;
  logic [BS_W-1:0]   rem;
  logic              rem_done, trig, close, last;

  // remainder of the hash by the configured divisor
  rhcb_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (hash_sum),
    .divisor_i  (bs_q),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // rolling update terms
  assign c_ext    = HASH_W'(byte_q);
  assign old_ext  = HASH_W'(win_q[wpos_q]);
  assign wtd_new  = wtd_q - wsum_q + HASH_W'(WINDOW) * c_ext;
  assign wsum_new = wsum_q + c_ext - old_ext;
  assign sx_new   = (sx_q << ROLL_SHIFT) ^ c_ext;
  assign wpos_new = (wpos_q == WIN_AW'(WINDOW - 1)) ? '0 : wpos_q + 1'b1;
  assign hash_sum = wsum_q + wtd_q + sx_q;

  // boundary decision
  assign trig  = (bs_q != '0) && (rem == bs_q - 1'b1);
  assign close = inch_q && (trig || (len_q >= mc_q));
  assign last  = (left_q == '0);

  assign sts_o.skip     = (skip_q != '0);
  assign sts_o.rem_done = rem_done;
  assign sts_o.out_free = !m_valid_q || out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= BLOCK_SIZE_RST;
      mc_q <= MAX_CHUNK_RST;
      sc_q <= SKIP_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_BLOCK_SIZE: bs_q <= cfg_wdata_i[BS_W-1:0];
        REG_MAX_CHUNK:  mc_q <= cfg_wdata_i[LEN_W-1:0];
        REG_SKIP_COUNT: sc_q <= cfg_wdata_i[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  // hash and chunk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
      wpos_q    <= '0;
      wsum_q    <= '0;
      wtd_q     <= '0;
      sx_q      <= '0;
      len_q     <= '0;
      skip_q    <= '0;
      inch_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        inch_q <= 1'b0;
      end
      if (cmd_i.roll) begin
        win_q[wpos_q] <= byte_q;
        wpos_q <= wpos_new;
        wsum_q <= wsum_new;
        wtd_q  <= wtd_new;
        sx_q   <= sx_new;
        len_q  <= len_q + 1'b1;
        inch_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        if (last) begin
          // stream end: back to the reset picture
          for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
          wpos_q <= '0;
          wsum_q <= '0;
          wtd_q  <= '0;
          sx_q   <= '0;
          len_q  <= '0;
          skip_q <= '0;
        end else if (!inch_q) begin
          skip_q <= skip_q - 1'b1;
        end else if (close) begin
          len_q <= '0;
          if (LEFT_W'(sc_q) <= left_q) begin
            skip_q <= sc_q;
          end
        end
      end
      if (cmd_i.commit) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= in_data_i[BYTE_W-1:0];
      left_q <= in_data_i[BYTE_W +: LEFT_W];
    end
    if (cmd_i.start) begin
      hash_q <= hash_sum;
    end
    if (cmd_i.commit) begin
      o_byte_q <= byte_q;
      o_inch_q <= inch_q;
      o_cend_q <= close;
      o_last_q <= last;
      o_roll_q <= inch_q ? hash_q : '0;
      o_pos_q  <= inch_q ? len_q : '0;
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_data_o  = {o_pos_q, o_roll_q, o_byte_q};
  assign out_user_o  = {o_cend_q, o_inch_q};
  assign out_last_o  = o_last_q;

  // remainder from the unit stays below a nonzero divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rem_done) && (bs_q != '0) |-> rem < bs_q)
    else $error("remainder not below the divisor");

  // a closed chunk restarts its length count
  a_close_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && close |=> len_q == '0)
    else $error("chunk length not cleared on close");

  // last byte leaves all hash state cleared
  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && last |=> (wsum_q == '0) && (wtd_q == '0) && (sx_q == '0)
      && (skip_q == '0) && (wpos_q == '0))
    else $error("state not cleared after last byte");

  // skipped bytes never roll the hash
  a_skip_no_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.roll |-> skip_q == '0)
    else $error("hash rolled while skipping");

  a_wpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= WIN_AW'(WINDOW - 1))
    else $error("window position out of range");

endmodule
`default_nettype wire

// ===== src/rhcb_ctrl.sv =====
`default_nettype none
module rhcb_ctrl
  import rhcb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire rhcb_sts_t sts_i,
  output rhcb_cmd_t      cmd_o,
  output logic           in_ready_o
);

  rhcb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ROLL;
        end
      end
      ST_ROLL: begin
        if (sts_i.skip) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.roll = 1'b1;
          state_d    = ST_HSUM;
        end
      end
      ST_HSUM: begin
        cmd_o.start = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.rem_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // one byte in flight: a new beat only from idle
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.roll && !cmd_o.start && !cmd_o.commit)
    else $error("input ready while a byte is in flight");

  // every accepted beat is rolled or skipped next cycle
  a_load_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_ROLL)
    else $error("accepted beat not processed");

  // the remainder is started exactly once per hashed byte
  a_start_after_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> $past(cmd_o.roll))
    else $error("remainder started without a rolled byte");

endmodule
`default_nettype wire

// ===== src/rolling_hash_chunk_boundary.sv =====
// A hashed byte passes the roll, hash-sum, remainder and finish states on its way to
//   m_axis, a skipped byte only roll and finish; the remainder unit is 8-step radix-16.
// Only one byte is in flight: a new beat is taken in idle, after the last one commits.
// The output register lets a new beat in while the previous result waits.
// Reset (rst_ni low, asynchronous): hash, window and chunk state clear,
//   configuration returns to divisor 320, max_chunk 16384, skip_count 80.
`default_nettype none
module rolling_hash_chunk_boundary
  import rhcb_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_AW-1:0]    cfg_addr_i,
  input  wire logic [CFG_DW-1:0]    cfg_wdata_i,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // data_byte[7:0], bytes_left[39:8]
  // output stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,   // out_byte[7:0], roll_value[39:8],
                                                    // chunk_pos[55:40]
  output logic [M_TUSER_W-1:0]      m_axis_tuser,   // in_chunk[0], chunk_end[1]
  output logic                      m_axis_tlast    // stream_end
);

  rhcb_cmd_t cmd;
  rhcb_sts_t sts;

  rhcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  rhcb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== test/rolling_hash_chunk_boundary_checker.sv =====
`timescale 1ns / 100ps
module rolling_hash_chunk_boundary_checker
  import rhcb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration port, observed
  input  logic                 cfg_we_i,
  input  logic [CFG_AW-1:0]    cfg_addr_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  // input stream, observed
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // data_byte[7:0], bytes_left[39:8]
  // output stream, observed
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,   // out_byte[7:0], roll_value[39:8],
                                               // chunk_pos[55:40]
  input  logic [M_TUSER_W-1:0] m_axis_tuser,   // in_chunk[0], chunk_end[1]
  input  logic                 m_axis_tlast,   // stream_end
  // status for the testbench top
  output int unsigned          pending_o,
  output int unsigned          errors_o,
  output int unsigned          bytes_o,
  output int unsigned          skipped_o,
  output int unsigned          boundaries_o,
  output int unsigned          streams_o
);

  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic              in_chunk;
    logic              chunk_end;
    logic              stream_end;
    logic [HASH_W-1:0] roll_value;
    logic [LEN_W-1:0]  chunk_pos;
  } chunk_result_t;

  // shadow configuration
  logic [BS_W-1:0]   div_size;
  logic [LEN_W-1:0]  max_chunk;
  logic [SKIP_W-1:0] skip_count;

  // shadow hash and chunk state
  logic [BYTE_W-1:0] win_bytes [WINDOW];
  logic [WIN_AW-1:0] win_pos;
  logic [HASH_W-1:0] win_sum;
  logic [HASH_W-1:0] wsum;
  logic [HASH_W-1:0] sxor;
  logic [LEN_W-1:0]  chunk_len;
  logic [SKIP_W-1:0] skip_left;

  chunk_result_t result_q [$];
  int unsigned   mismatches;
  int unsigned   n_bytes, n_skipped, n_bounds, n_streams;

  function automatic void clear_chunker();
    foreach (win_bytes[i]) win_bytes[i] = '0;
    win_pos   = '0;
    win_sum   = '0;
    wsum      = '0;
    sxor      = '0;
    chunk_len = '0;
    skip_left = '0;
  endfunction

  // advance the shadow chunker by one byte and return the result it implies
  function automatic chunk_result_t chunk_next(input logic [BYTE_W-1:0] c,
                                               input logic [LEFT_W-1:0] left);
    chunk_result_t     r;
    logic [HASH_W-1:0] c_w;
    logic [HASH_W-1:0] old_w;
    logic              trig;
    r = '{out_byte: c, in_chunk: 1'b0, chunk_end: 1'b0, stream_end: (left == '0),
          roll_value: '0, chunk_pos: '0};
    if (skip_left != '0) begin
      skip_left = skip_left - 1'b1;
    end else begin
      c_w   = HASH_W'(c);
      old_w = HASH_W'(win_bytes[win_pos]);
      wsum = wsum - win_sum + HASH_W'(WINDOW) * c_w;
      win_sum = win_sum + c_w - old_w;
      win_bytes[win_pos] = c;
      win_pos = (win_pos == WIN_AW'(WINDOW - 1)) ? '0 : win_pos + 1'b1;
      sxor = (sxor << ROLL_SHIFT) ^ c_w;
      r.roll_value = win_sum + wsum + sxor;
      r.in_chunk = 1'b1;
      chunk_len = chunk_len + 1'b1;
      r.chunk_pos = chunk_len;
      trig = (div_size != '0) &&
             (r.roll_value % HASH_W'(div_size) == HASH_W'(div_size) - HASH_W'(1));
      if (trig || chunk_len >= max_chunk) begin
        r.chunk_end = 1'b1;
        chunk_len = '0;
        if (LEFT_W'(skip_count) <= left) skip_left = skip_count;
      end
    end
    if (r.stream_end) clear_chunker();
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    chunk_result_t want;
    if (!rst_ni) begin
      div_size   = BLOCK_SIZE_RST;
      max_chunk  = MAX_CHUNK_RST;
      skip_count = SKIP_COUNT_RST;
      clear_chunker();
      result_q.delete();
      mismatches = 0;
      n_bytes = 0;
      n_skipped = 0;
      n_bounds = 0;
      n_streams = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_BLOCK_SIZE: div_size   = cfg_wdata_i[BS_W-1:0];
          REG_MAX_CHUNK:  max_chunk  = cfg_wdata_i[LEN_W-1:0];
          REG_SKIP_COUNT: skip_count = cfg_wdata_i[SKIP_W-1:0];
          default: ;
        endcase
      end
      // result beat against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $error("result beat with no byte outstanding (tdata 0x%0h)", m_axis_tdata);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(m_axis_tdata[7:0]));
          check_field("roll_value", want.roll_value, m_axis_tdata[39:8]);
          check_field("chunk_pos", 32'(want.chunk_pos), 32'(m_axis_tdata[55:40]));
          check_field("in_chunk", 32'(want.in_chunk), 32'(m_axis_tuser[0]));
          check_field("chunk_end", 32'(want.chunk_end), 32'(m_axis_tuser[1]));
          check_field("stream_end", 32'(want.stream_end), 32'(m_axis_tlast));
        end
      end
      // input beat
      if (s_axis_tvalid && s_axis_tready) begin
        want = chunk_next(s_axis_tdata[7:0], s_axis_tdata[39:8]);
        result_q.push_back(want);
        n_bytes++;
        if (!want.in_chunk) n_skipped++;
        if (want.chunk_end) n_bounds++;
        if (want.stream_end) n_streams++;
      end
    end
    pending_o    <= result_q.size();
    errors_o     <= mismatches;
    bytes_o      <= n_bytes;
    skipped_o    <= n_skipped;
    boundaries_o <= n_bounds;
    streams_o    <= n_streams;
  end

endmodule

// ===== test/tb_rolling_hash_chunk_boundary.sv =====
`timescale 1ns / 100ps
module tb_rolling_hash_chunk_boundary;
  import rhcb_pkg::*;

  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_BYTES = 120;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 3000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]    cfg_addr_i = '0;
  logic [CFG_DW-1:0]    cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // data_byte[7:0], bytes_left[39:8]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // out_byte[7:0], roll_value[39:8],
                                             // chunk_pos[55:40]
  logic [M_TUSER_W-1:0] m_axis_tuser;        // in_chunk[0], chunk_end[1]
  logic                 m_axis_tlast;        // stream_end

  int unsigned pending, errors, n_bytes, n_skipped, n_bounds, n_streams;
  int unsigned n_settings = 1;

  // idling modes, shared by the source and sink processes
  bit src_quiet  = 1'b0;
  bit sink_quiet = 1'b0;
  bit hold_req   = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rolling_hash_chunk_boundary DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  rolling_hash_chunk_boundary_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .pending_o    (pending),
    .errors_o     (errors),
    .bytes_o      (n_bytes),
    .skipped_o    (n_skipped),
    .boundaries_o (n_bounds),
    .streams_o    (n_streams)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // bytes_left that need not fit any stream
  function automatic logic [LEFT_W-1:0] rand_left();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return LEFT_W'($urandom_range(1, 300));
      default: return LEFT_W'($urandom());
    endcase
  endfunction

  task automatic program_regs(input logic [BS_W-1:0] bs, input logic [LEN_W-1:0] mc,
                              input logic [SKIP_W-1:0] sk);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_BLOCK_SIZE;
    cfg_wdata_i <= CFG_DW'(bs);
    @(posedge clk_i);
    cfg_addr_i  <= REG_MAX_CHUNK;
    cfg_wdata_i <= CFG_DW'(mc);
    @(posedge clk_i);
    cfg_addr_i  <= REG_SKIP_COUNT;
    cfg_wdata_i <= CFG_DW'(sk);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
  endtask

  // offer one beat and return at the edge that takes it
  task automatic push_byte(input logic [BYTE_W-1:0] c, input logic [LEFT_W-1:0] left);
    int unsigned gap;
    gap = src_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {left, c};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // well-formed stream: bytes_left counts down to zero
  task automatic send_stream(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_byte(rand_byte(), LEFT_W'(len - 1 - i));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // result sink: random stalls, quiet stretches and one long hold-off
  initial begin : sink
    int unsigned stall_left;
    int unsigned gap;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        gap = sink_quiet ? 0 : pick_gap();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          stall_left = gap - 1;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // watchdog: too long without any beat on either side
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no beat for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending);
    $display("** rolling_hash_chunk_boundary: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned       sent, len;
    logic [BS_W-1:0]   bs;
    logic [LEN_W-1:0]  mc;
    logic [SKIP_W-1:0] sk;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, byte extremes, stream end
    push_byte(8'h00, 2);
    push_byte(8'hFF, 1);
    push_byte(8'hA5, 0);
    wait_idle();

    // every byte triggers; a long skip cut short by a stream end, then a skip
    // refused because too few bytes follow, last byte closing a chunk
    program_regs(16'd1, 16'hFFFF, 8'hFF);
    push_byte(8'h5A, 32'hFFFF_FFFF);
    push_byte(8'hC3, 0);
    push_byte(8'h33, 3);
    push_byte(8'hFF, 2);
    push_byte(8'h00, 0);
    wait_idle();

    // no hash trigger, length closes at 3, skip of 2 between chunks
    program_regs(16'd0, 16'd3, 8'd2);
    send_stream(8);
    wait_idle();

    // zero max_chunk closes every hashed byte; skip runs over the last byte
    program_regs(16'hFFFF, 16'd0, 8'd2);
    send_stream(3);
    wait_idle();

    // no skipping at all
    program_regs(16'd2, 16'hFFFF, 8'd0);
    send_stream(4);
    wait_idle();

    // random phases, each under its own register setting
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          bs = BS_W'($urandom_range(2, 40));
          mc = 16'hFFFF;
          sk = SKIP_W'($urandom_range(0, 20));
        end
        1: begin bs = 16'hFFFF; mc = 16'hFFFF; sk = 8'hFF; end
        2: begin bs = 16'd0;    mc = 16'd1;    sk = 8'd0;  end
        3: begin bs = 16'd1;    mc = 16'd0;    sk = 8'hFF; end
        default: begin
          case ($urandom_range(0, 3))
            0:       bs = BS_W'($urandom_range(1, 8));
            1:       bs = BS_W'($urandom_range(9, 200));
            2:       bs = BS_W'($urandom_range(0, 65535));
            default: bs = 16'd0;
          endcase
          case ($urandom_range(0, 3))
            0:       mc = LEN_W'($urandom_range(1, 10));
            1:       mc = LEN_W'($urandom_range(11, 300));
            2:       mc = 16'hFFFF;
            default: mc = LEN_W'($urandom_range(0, 65535));
          endcase
          case ($urandom_range(0, 3))
            0:       sk = 8'd0;
            1:       sk = SKIP_W'($urandom_range(1, 8));
            2:       sk = SKIP_W'($urandom_range(9, 60));
            default: sk = SKIP_W'($urandom_range(0, 255));
          endcase
        end
      endcase
      program_regs(bs, mc, sk);

      // first phase: sender back to back while the sink holds off
      src_quiet  = (p == 0) || (p % 4 == 2);
      sink_quiet = (p % 4 == 2);
      if (p == 0) hold_req = 1'b1;

      sent = 0;
      while (sent < PHASE_BYTES) begin
        if ($urandom_range(0, 4) != 0) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(61, 300) : $urandom_range(1, 60);
          if (len > PHASE_BYTES - sent) len = PHASE_BYTES - sent;
          send_stream(len);
        end else begin
          // noise: bytes_left unrelated to the stream
          len = $urandom_range(1, 4);
          for (int unsigned k = 0; k < len; k++) push_byte(rand_byte(), rand_left());
        end
        sent += len;
      end
      wait_idle();
    end

    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    repeat (20) @(posedge clk_i);

    $display("Run: %0d bytes over %0d register settings, %0d of them skipped",
             n_bytes, n_settings, n_skipped);
    $display("Run: %0d chunk boundaries, %0d stream ends, %0d mismatches",
             n_bounds, n_streams, errors);
    if (errors == 0 && pending == 0)
      $display("** rolling_hash_chunk_boundary: PASSED **");
    else
      $display("** rolling_hash_chunk_boundary: FAILED **");
    $finish;
  end

endmodule
